>>> hdl/ptht_pkg.sv
// ----------------------------------------------------------------------------
// ptht_pkg
// Shared types and constants for the preorder tree table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptht_pkg;

   localparam int CAPACITY  = 256;
   localparam int ID_BITS   = 24;
   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS  = ADDR_BITS + 1;
   localparam int DEP_BITS  = 8;
   localparam int RANK_BITS = 8;
   localparam int OUT_CNT_BITS = 9;

   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_REPARENT = 3'd2,
      OP_CHILDREN = 3'd3,
      OP_DESCEND = 3'd4,
      OP_GET_CHILD = 3'd5
   } op_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [ID_BITS-1:0]  parent;
      logic [DEP_BITS-1:0] depth;
   } row_type;

endpackage

`default_nettype wire

>>> hdl/ptht_ram.sv
// ----------------------------------------------------------------------------
// ptht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hdl/preorder_tree_hierarchy_table.sv
// ----------------------------------------------------------------------------
// preorder_tree_hierarchy_table
// Forest kept as a preorder table with create, remove, reparent and queries.
// ----------------------------------------------------------------------------
// One transaction at a time. The table lives in a row RAM (id, parent, depth)
// read one row per cycle; every scan streams through it at one row a cycle.
// Queries take one lookup scan plus one subtree scan; a query on key zero
// takes one whole-table scan instead. Remove and reparent add a copy of the
// table into a scratch RAM and a rebuild pass back. A result waits in its
// output register while the next request is taken. The table needs no
// clearing after reset: only rows below the row count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module preorder_tree_hierarchy_table
   import ptht_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [2:0]              req_opcode,
   input  wire logic [ID_BITS-1:0]      req_node_key,
   input  wire logic [ID_BITS-1:0]      req_new_parent,
   input  wire logic [RANK_BITS-1:0]    req_child_rank,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_ok,
   output logic [ID_BITS-1:0]           rsp_id_result,
   output logic [OUT_CNT_BITS-1:0]      rsp_count_result
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_FIND_KEY, ST_SUB_SCAN, ST_FIND_PAR,
      ST_COPY, ST_MOVE, ST_QSCAN, ST_QDONE, ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [ID_BITS-1:0]     key_ff, key_in, par_ff, par_in;
   logic [RANK_BITS-1:0]   rank_ff, rank_in;
   logic [CNT_BITS-1:0]    rc_ff, rc_in;
   logic [ID_BITS-1:0]     idc_ff, idc_in;
   // streaming read engine
   logic [CNT_BITS-1:0]    issue_ff, issue_in, pidx_ff, pidx_in;
   logic                   pend_ff, pend_in;
   logic                   sub_ff, sub_in, first_ff, first_in;
   // operation context
   logic [CNT_BITS-1:0]    row_ff, row_in, end_ff, end_in, ins_ff, ins_in;
   logic [DEP_BITS-1:0]    drow_ff, drow_in, shift_ff, shift_in;
   logic                   root_ff, root_in, kf_ff, kf_in;
   logic [CNT_BITS-1:0]    ch_ff, ch_in, de_ff, de_in;
   logic [ID_BITS-1:0]     kth_ff, kth_in;
   // staged result
   logic                   res_ok_ff, res_ok_in;
   logic [ID_BITS-1:0]     res_id_ff, res_id_in;
   logic [OUT_CNT_BITS-1:0] res_cnt_ff, res_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_ok_ff, rsp_ok_in;
   logic [ID_BITS-1:0]     rsp_id_ff, rsp_id_in;
   logic [OUT_CNT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;

   // RAM ports
   logic                   a_we, b_we;
   logic [ADDR_BITS-1:0]   a_waddr, a_raddr, b_raddr;
   row_type                a_wdata, a_rdata, b_rdata;

   logic [CNT_BITS-1:0]    limit, n_sub, mv_limit, src, end_v, n_v, nx;
   logic                   issue_en, exhausted;
   logic [ID_BITS-1:0]     nid;
   row_type                mv_row;

   ptht_ram #(.WIDTH($bits(row_type)), .DEPTH(CAPACITY)) u_table (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata(a_rdata)
   );

   ptht_ram #(.WIDTH($bits(row_type)), .DEPTH(CAPACITY)) u_scratch (
      .clock(clock), .we(b_we), .waddr(pidx_ff[ADDR_BITS-1:0]), .wdata(a_rdata),
      .raddr(b_raddr), .rdata(b_rdata)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_id_result    = rsp_id_ff;
   assign rsp_count_result = rsp_cnt_ff;

   assign n_sub    = end_ff - row_ff;
   assign mv_limit = (op_ff == OP_REMOVE) ? rc_ff - n_sub : rc_ff;
   assign limit    = (state_ff == ST_MOVE) ? mv_limit : rc_ff;
   assign issue_en = (issue_ff < limit);
   assign exhausted = !pend_ff && !issue_en;
   assign nid      = ((idc_ff + 1'b1) == '0) ? ID_BITS'(1) : idc_ff + 1'b1;
   // subtree end as seen by the current sub scan row
   assign end_v    = (state_ff == ST_SUB_SCAN && pend_ff) ? pidx_ff : rc_ff;
   assign n_v      = end_v - row_ff;

   // rebuild source row: the table with the subtree cut out, subtree at ins
   always_comb begin
      sub_in   = 1'b0;
      first_in = 1'b0;
      nx       = issue_ff;
      if (issue_ff < ins_ff) begin
         nx = issue_ff;
      end else if (issue_ff < ins_ff + n_sub) begin
         sub_in   = 1'b1;
         first_in = (issue_ff == ins_ff);
         nx       = '0;
      end else begin
         nx = issue_ff - n_sub;
      end
      if (sub_in) begin
         src = row_ff + (issue_ff - ins_ff);
      end else begin
         src = (nx < row_ff) ? nx : nx + n_sub;
      end
   end

   always_comb begin
      mv_row = b_rdata;
      if (sub_ff) begin
         mv_row.depth = b_rdata.depth - drow_ff + shift_ff;
      end
      if (first_ff) begin
         mv_row.parent = par_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; key_in = key_ff; par_in = par_ff; rank_in = rank_ff;
      rc_in = rc_ff; idc_in = idc_ff;
      issue_in = issue_en ? issue_ff + 1'b1 : issue_ff;
      pend_in  = issue_en;
      pidx_in  = issue_ff;
      row_in = row_ff; end_in = end_ff; ins_in = ins_ff;
      drow_in = drow_ff; shift_in = shift_ff;
      root_in = root_ff; kf_in = kf_ff; ch_in = ch_ff; de_in = de_ff; kth_in = kth_ff;
      res_ok_in = res_ok_ff; res_id_in = res_id_ff; res_cnt_in = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in = rsp_ok_ff; rsp_id_in = rsp_id_ff; rsp_cnt_in = rsp_cnt_ff;
      a_we = 1'b0; a_waddr = pidx_ff[ADDR_BITS-1:0]; a_wdata = mv_row;
      a_raddr = issue_ff[ADDR_BITS-1:0];
      b_we = 1'b0; b_raddr = src[ADDR_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            pend_in = 1'b0;
            if (req_valid) begin
               op_in = op_type'(req_opcode);
               key_in = req_node_key; par_in = req_new_parent; rank_in = req_child_rank;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_ok_in = 1'b0; res_id_in = '0; res_cnt_in = '0;
            issue_in = '0; pend_in = 1'b0;
            root_in = 1'b0; kf_in = 1'b0; ch_in = '0; de_in = '0; kth_in = '0;
            state_in = ST_FINISH;
            case (op_ff)
               OP_CREATE: begin
                  if (rc_ff < CNT_BITS'(CAPACITY)) begin
                     a_we = 1'b1;
                     a_waddr = rc_ff[ADDR_BITS-1:0];
                     a_wdata = '{id: nid, parent: '0, depth: '0};
                     rc_in = rc_ff + 1'b1;
                     idc_in = nid;
                     res_ok_in = 1'b1;
                     res_id_in = nid;
                  end
               end
               OP_REMOVE, OP_REPARENT: begin
                  if (key_ff != '0) state_in = ST_FIND_KEY;
               end
               OP_CHILDREN, OP_DESCEND, OP_GET_CHILD: begin
                  if (key_ff == '0) begin
                     root_in = 1'b1;
                     state_in = ST_QSCAN;
                  end else begin
                     state_in = ST_FIND_KEY;
                  end
               end
               default: ;
            endcase
         end
         ST_FIND_KEY: begin
            if (pend_ff && a_rdata.id == key_ff) begin
               row_in = pidx_ff;
               drow_in = a_rdata.depth;
               issue_in = pidx_ff + 1'b1;
               pend_in = 1'b0;
               if (op_ff == OP_REMOVE || op_ff == OP_REPARENT) begin
                  state_in = ST_SUB_SCAN;
               end else begin
                  state_in = ST_QSCAN;
               end
            end else if (exhausted) begin
               state_in = ST_FINISH;
            end
         end
         ST_SUB_SCAN: begin
            if ((pend_ff && !(a_rdata.depth > drow_ff)) || exhausted) begin
               end_in = end_v;
               issue_in = '0;
               pend_in = 1'b0;
               ins_in = rc_ff - n_v;
               shift_in = '0;
               if (op_ff == OP_REPARENT && par_ff != '0) begin
                  state_in = ST_FIND_PAR;
               end else begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_FIND_PAR: begin
            if (pend_ff && a_rdata.id == par_ff) begin
               issue_in = '0;
               pend_in = 1'b0;
               shift_in = a_rdata.depth + 1'b1;
               if (pidx_ff >= row_ff && pidx_ff < end_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  ins_in = (pidx_ff < row_ff) ? pidx_ff + 1'b1 : pidx_ff - n_sub + 1'b1;
                  state_in = ST_COPY;
               end
            end else if (exhausted) begin
               state_in = ST_FINISH;
            end
         end
         ST_COPY: begin
            b_we = pend_ff;
            if (exhausted) begin
               issue_in = '0;
               pend_in = 1'b0;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            a_we = pend_ff;
            if (exhausted) begin
               rc_in = mv_limit;
               res_ok_in = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_QSCAN: begin
            if (pend_ff && !root_ff && a_rdata.depth <= drow_ff) begin
               state_in = ST_QDONE;
            end else if (pend_ff) begin
               de_in = de_ff + 1'b1;
               if ((root_ff && a_rdata.depth == '0) ||
                   (!root_ff && a_rdata.depth == drow_ff + 1'b1 && drow_ff != '1)) begin
                  if (!kf_ff && ch_ff == CNT_BITS'(rank_ff)) begin
                     kth_in = a_rdata.id;
                     kf_in = 1'b1;
                  end
                  ch_in = ch_ff + 1'b1;
               end
            end else if (exhausted) begin
               state_in = ST_QDONE;
            end
         end
         ST_QDONE: begin
            pend_in = 1'b0;
            case (op_ff)
               OP_CHILDREN: begin
                  res_ok_in = 1'b1; res_cnt_in = OUT_CNT_BITS'(ch_ff);
               end
               OP_DESCEND: begin
                  res_ok_in = 1'b1; res_cnt_in = OUT_CNT_BITS'(de_ff);
               end
               default: begin
                  res_ok_in = kf_ff; res_id_in = kf_ff ? kth_ff : '0;
               end
            endcase
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            pend_in = 1'b0;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in = res_ok_ff; rsp_id_in = res_id_ff; rsp_cnt_in = res_cnt_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rc_ff <= '0;
         idc_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rc_ff <= rc_in;
         idc_ff <= idc_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in; key_ff <= key_in; par_ff <= par_in; rank_ff <= rank_in;
      issue_ff <= issue_in; pidx_ff <= pidx_in; sub_ff <= sub_in; first_ff <= first_in;
      row_ff <= row_in; end_ff <= end_in; ins_ff <= ins_in;
      drow_ff <= drow_in; shift_ff <= shift_in;
      root_ff <= root_in; kf_ff <= kf_in; ch_ff <= ch_in; de_ff <= de_in; kth_ff <= kth_in;
      res_ok_ff <= res_ok_in; res_id_ff <= res_id_in; res_cnt_ff <= res_cnt_in;
      rsp_ok_ff <= rsp_ok_in; rsp_id_ff <= rsp_id_in; rsp_cnt_ff <= rsp_cnt_in;
   end

endmodule

`default_nettype wire
